[rtl/closest_points_two_lines_unit_macros.svh]
// ---------------------------------------------------------------------------
// closest points unit assertion macros
// shared assertion shorthands for the closest points unit
// ---------------------------------------------------------------------------
`ifndef CLOSEST_POINTS_TWO_LINES_UNIT_MACROS_SVH
`define CLOSEST_POINTS_TWO_LINES_UNIT_MACROS_SVH

// clocked check, off while in reset
`define CLPT_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// antecedent implies consequent in the same cycle
`define CLPT_IMPLY(lbl, ante, cons, msg) \
	`CLPT_CHECK(lbl, (ante) |-> (cons), msg)

`endif

[rtl/clpt_pkg.sv]
// ---------------------------------------------------------------------------
// clpt_pkg
// types and constants of the closest points unit
// ---------------------------------------------------------------------------
package clpt_pkg;

	localparam int DIV_STEPS = 33;
	localparam int DEN_W = 64;
	localparam int MAG_W = 84;
	localparam logic [31:0] THR_RESET = 32'd268;
	localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
	localparam logic [31:0] NEG_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [31:0] first_start_x;
		logic signed [31:0] first_start_y;
		logic signed [31:0] first_start_z;
		logic signed [15:0] first_dir_x;
		logic signed [15:0] first_dir_y;
		logic signed [15:0] first_dir_z;
		logic signed [31:0] second_start_x;
		logic signed [31:0] second_start_y;
		logic signed [31:0] second_start_z;
		logic signed [15:0] second_dir_x;
		logic signed [15:0] second_dir_y;
		logic signed [15:0] second_dir_z;
	} in_t;

	typedef struct packed {
		logic valid_res;
		logic signed [31:0] along_first;
		logic signed [31:0] along_second;
		logic saturated;
	} out_t;

	typedef struct packed {
		logic signed [33:0] a;
		logic signed [33:0] b;
		logic signed [33:0] c;
		logic signed [50:0] d;
		logic signed [50:0] e;
	} dot_t;

	typedef struct packed {
		logic sgn;
		logic ovf;
		logic [DEN_W-1:0] rem;
		logic [DIV_STEPS-1:0] low;
		logic [DIV_STEPS-1:0] quo;
	} lane_t;

	typedef struct packed {
		logic par;
		logic [DEN_W-1:0] den;
		lane_t first;
		lane_t second;
	} stage_t;

endpackage

[rtl/clpt_front.sv]
// ---------------------------------------------------------------------------
// clpt_front
// start point difference and the five dot products, two stages
// ---------------------------------------------------------------------------
module clpt_front (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  clpt_pkg::in_t in_item,
	output logic dot_valid,
	output clpt_pkg::dot_t dot
);
	import clpt_pkg::*;

	logic signed [32:0] w_s1 [3];
	logic signed [15:0] p_s1 [3];
	logic signed [15:0] q_s1 [3];
	logic v_s1, v_s2;
	dot_t dot_s2;
	dot_t dot_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1[0] <= 33'(in_item.first_start_x) - 33'(in_item.second_start_x);
			w_s1[1] <= 33'(in_item.first_start_y) - 33'(in_item.second_start_y);
			w_s1[2] <= 33'(in_item.first_start_z) - 33'(in_item.second_start_z);
			p_s1[0] <= in_item.first_dir_x;
			p_s1[1] <= in_item.first_dir_y;
			p_s1[2] <= in_item.first_dir_z;
			q_s1[0] <= in_item.second_dir_x;
			q_s1[1] <= in_item.second_dir_y;
			q_s1[2] <= in_item.second_dir_z;
			dot_s2 <= dot_w;
		end
	end

	always_comb begin
		dot_w.a = 34'(p_s1[0] * p_s1[0]) + 34'(p_s1[1] * p_s1[1]) + 34'(p_s1[2] * p_s1[2]);
		dot_w.b = 34'(p_s1[0] * q_s1[0]) + 34'(p_s1[1] * q_s1[1]) + 34'(p_s1[2] * q_s1[2]);
		dot_w.c = 34'(q_s1[0] * q_s1[0]) + 34'(q_s1[1] * q_s1[1]) + 34'(q_s1[2] * q_s1[2]);
		dot_w.d = 51'(p_s1[0] * w_s1[0]) + 51'(p_s1[1] * w_s1[1]) + 51'(p_s1[2] * w_s1[2]);
		dot_w.e = 51'(q_s1[0] * w_s1[0]) + 51'(q_s1[1] * w_s1[1]) + 51'(q_s1[2] * w_s1[2]);
	end

	assign dot_valid = v_s2;
	assign dot = dot_s2;

endmodule

[rtl/clpt_prod.sv]
// ---------------------------------------------------------------------------
// clpt_prod
// determinant, numerators, parallel test and divider set-up, four stages
// ---------------------------------------------------------------------------
module clpt_prod (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic [31:0] thr,
	input  logic dot_valid,
	input  clpt_pkg::dot_t dot,
	output logic stg_valid,
	output clpt_pkg::stage_t stg
);
	import clpt_pkg::*;

	logic v_s3, v_s4, v_s5, v_s6;
	logic signed [25:0] d_lo, d_hi, e_lo, e_hi;
	logic signed [67:0] ac_s3, bb_s3;
	logic signed [59:0] bel_s3, beh_s3, cdl_s3, cdh_s3;
	logic signed [59:0] ael_s3, aeh_s3, bdl_s3, bdh_s3;
	logic signed [67:0] den_w;
	logic signed [84:0] n1_w, n2_w;
	logic signed [84:0] n1_s4, n2_s4;
	logic [DEN_W-1:0] den_s4, den_s5;
	logic par_s4, par_s5;
	logic signed [84:0] neg1_w, neg2_w;
	logic sgn1_s5, sgn2_s5;
	logic [MAG_W-1:0] mag1_s5, mag2_s5;
	logic [MAG_W+13:0] dvd1_w, dvd2_w;
	stage_t stg_s6;

	assign d_lo = {1'b0, dot.d[24:0]};
	assign d_hi = dot.d[50:25];
	assign e_lo = {1'b0, dot.e[24:0]};
	assign e_hi = dot.e[50:25];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s3 <= dot_valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_comb begin
		den_w = ac_s3 - bb_s3;
		n1_w = (85'(beh_s3) <<< 25) + 85'(bel_s3) - (85'(cdh_s3) <<< 25) - 85'(cdl_s3);
		n2_w = (85'(aeh_s3) <<< 25) + 85'(ael_s3) - (85'(bdh_s3) <<< 25) - 85'(bdl_s3);
		neg1_w = -n1_s4;
		neg2_w = -n2_s4;
		dvd1_w = {mag1_s5, 14'b0};
		dvd2_w = {mag2_s5, 14'b0};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 3: split products
			ac_s3 <= 68'(dot.a * dot.c);
			bb_s3 <= 68'(dot.b * dot.b);
			bel_s3 <= 60'(dot.b * e_lo);
			beh_s3 <= 60'(dot.b * e_hi);
			cdl_s3 <= 60'(dot.c * d_lo);
			cdh_s3 <= 60'(dot.c * d_hi);
			ael_s3 <= 60'(dot.a * e_lo);
			aeh_s3 <= 60'(dot.a * e_hi);
			bdl_s3 <= 60'(dot.b * d_lo);
			bdh_s3 <= 60'(dot.b * d_hi);
			// stage 4: determinant and numerators
			den_s4 <= den_w[DEN_W-1:0];
			n1_s4 <= n1_w;
			n2_s4 <= n2_w;
			par_s4 <= (den_w[DEN_W-1:0] == '0) || (den_w[DEN_W-1:28] < 36'(thr));
			// stage 5: sign and magnitude
			den_s5 <= den_s4;
			par_s5 <= par_s4;
			sgn1_s5 <= n1_s4[84];
			sgn2_s5 <= n2_s4[84];
			mag1_s5 <= n1_s4[84] ? neg1_w[MAG_W-1:0] : n1_s4[MAG_W-1:0];
			mag2_s5 <= n2_s4[84] ? neg2_w[MAG_W-1:0] : n2_s4[MAG_W-1:0];
			// stage 6: overflow test and first partial remainder
			stg_s6.par <= par_s5;
			stg_s6.den <= den_s5;
			stg_s6.first.sgn <= sgn1_s5;
			stg_s6.first.ovf <= dvd1_w[MAG_W+13:DIV_STEPS] >= {1'b0, den_s5};
			stg_s6.first.rem <= dvd1_w[MAG_W+12:DIV_STEPS];
			stg_s6.first.low <= dvd1_w[DIV_STEPS-1:0];
			stg_s6.first.quo <= '0;
			stg_s6.second.sgn <= sgn2_s5;
			stg_s6.second.ovf <= dvd2_w[MAG_W+13:DIV_STEPS] >= {1'b0, den_s5};
			stg_s6.second.rem <= dvd2_w[MAG_W+12:DIV_STEPS];
			stg_s6.second.low <= dvd2_w[DIV_STEPS-1:0];
			stg_s6.second.quo <= '0;
		end
	end

	assign stg_valid = v_s6;
	assign stg = stg_s6;

endmodule

[rtl/clpt_div.sv]
// ---------------------------------------------------------------------------
// clpt_div
// pipelined restoring divider, one quotient bit per stage, two lanes,
// then sign, clipping and the output register
// ---------------------------------------------------------------------------
module clpt_div (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic stg_valid,
	input  clpt_pkg::stage_t stg,
	output logic out_valid,
	output clpt_pkg::out_t out_item
);
	import clpt_pkg::*;

	stage_t step_s [DIV_STEPS];
	stage_t nxt [DIV_STEPS];
	logic [DIV_STEPS-1:0] vstep_s;
	logic vout_s;
	out_t out_s;
	out_t res_w;
	logic [32:0] fin1_w, fin2_w;

	function automatic lane_t step_lane(lane_t l, logic [DEN_W-1:0] den);
		logic [DEN_W:0] r;
		logic [DEN_W:0] diff;
		logic ge;
		lane_t o;
		r = {l.rem, l.low[DIV_STEPS-1]};
		diff = r - {1'b0, den};
		ge = r >= {1'b0, den};
		o = l;
		o.rem = ge ? diff[DEN_W-1:0] : r[DEN_W-1:0];
		o.low = {l.low[DIV_STEPS-2:0], 1'b0};
		o.quo = {l.quo[DIV_STEPS-2:0], ge};
		return o;
	endfunction

	// returns clip flag and value
	function automatic logic [32:0] finish(lane_t l);
		logic clip;
		logic [DIV_STEPS-1:0] neg;
		neg = -l.quo;
		if (l.sgn) begin
			clip = l.ovf || l.quo[32] || (l.quo[31] && (l.quo[30:0] != '0));
			return {clip, clip ? NEG_MIN : neg[31:0]};
		end
		clip = l.ovf || l.quo[32] || l.quo[31];
		return {clip, clip ? POS_MAX : l.quo[31:0]};
	endfunction

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		stage_t src;
		if (k == 0) begin : g_head
			assign src = stg;
		end else begin : g_body
			assign src = step_s[k-1];
		end
		always_comb begin
			nxt[k] = src;
			nxt[k].first = step_lane(src.first, src.den);
			nxt[k].second = step_lane(src.second, src.den);
		end
	end

	always_comb begin
		fin1_w = finish(step_s[DIV_STEPS-1].first);
		fin2_w = finish(step_s[DIV_STEPS-1].second);
		if (step_s[DIV_STEPS-1].par) begin
			res_w = '0;
		end else begin
			res_w.valid_res = 1'b1;
			res_w.along_first = fin1_w[31:0];
			res_w.along_second = fin2_w[31:0];
			res_w.saturated = fin1_w[32] | fin2_w[32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vstep_s <= '0;
			vout_s <= 1'b0;
		end else if (adv) begin
			vstep_s <= {vstep_s[DIV_STEPS-2:0], stg_valid};
			vout_s <= vstep_s[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				step_s[k] <= nxt[k];
			end
			out_s <= res_w;
		end
	end

	assign out_valid = vout_s;
	assign out_item = out_s;

endmodule

[rtl/closest_points_two_lines_unit.sv]
// ---------------------------------------------------------------------------
// closest_points_two_lines_unit
// line parameters of the closest points between two 3d lines
//
//   channel  signals                           direction
//   in       in_valid in_ready in_item         line pair in
//   out      out_valid out_ready out_item      parameters out
//   cfg      cfg_we cfg_wdata                  parallel threshold write
//
// one item per cycle while no result is held: six arithmetic stages,
// 33 divider stages (one quotient bit each), one output register
// reset clears valid bits and loads the threshold with 268
// a held result stalls the whole pipeline; in_ready is low only then
// ---------------------------------------------------------------------------
`include "closest_points_two_lines_unit_macros.svh"

module closest_points_two_lines_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  clpt_pkg::in_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output clpt_pkg::out_t out_item,
	input  logic cfg_we,
	input  logic [31:0] cfg_wdata
);
	import clpt_pkg::*;

	logic [31:0] thr_q;
	logic adv;
	logic dot_valid;
	dot_t dot;
	logic stg_valid;
	stage_t stg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	clpt_front u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(in_valid), .in_item(in_item),
		.dot_valid(dot_valid), .dot(dot)
	);

	clpt_prod u_prod (
		.clk(clk), .arst_n(arst_n), .adv(adv), .thr(thr_q),
		.dot_valid(dot_valid), .dot(dot),
		.stg_valid(stg_valid), .stg(stg)
	);

	clpt_div u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.stg_valid(stg_valid), .stg(stg),
		.out_valid(out_valid), .out_item(out_item)
	);

	`CLPT_IMPLY(a_par_zero, out_valid && !out_item.valid_res,
		out_item.along_first == 0 && out_item.along_second == 0 && !out_item.saturated,
		"parallel result carries nonzero fields")
	`CLPT_IMPLY(a_sat_clip, out_valid && out_item.saturated,
		out_item.along_first == POS_MAX || out_item.along_first == NEG_MIN ||
		out_item.along_second == POS_MAX || out_item.along_second == NEG_MIN,
		"saturation flag without a clipped parameter")
	`CLPT_CHECK(a_free_ready, !out_valid |-> in_ready, "input blocked with empty output")

endmodule
